// ----- src/assert_macros.svh -----
// Assertion macros shared by the scaler RTL.
// Depends on nothing; the using module provides the clock and reset signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/bir_pkg.sv -----
// Package of the bilinear image scaler: field widths, frame geometry and codes.
// Depends on nothing.
package bir_pkg;

   localparam int MAX_SRC_WIDTH  = 512;
   localparam int MAX_SRC_HEIGHT = 512;
   localparam int COL_BITS       = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_SRC_HEIGHT);
   localparam int ADDR_BITS      = COL_BITS + ROW_BITS;
   localparam int FRAME_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

   localparam int POS_BITS   = 12;
   localparam int SIZE_BITS  = 10;
   localparam int STEP_BITS  = 25;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_BITS  = STEP_BITS + POS_BITS;
   localparam int INT_BITS   = PROD_BITS - FRAC_BITS;
   localparam int PIXEL_BITS = 24;
   localparam int OUT_BITS   = 32;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = STEP_BITS;
   localparam int HSUM_BITS  = 8 + FRAC_BITS;
   localparam int VSUM_BITS  = HSUM_BITS + FRAC_BITS;

   localparam logic [7:0] ALPHA = 8'hff;
   localparam logic [FRAC_BITS:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_COMPUTE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_X_STEP     = 2'd2,
      CSR_Y_STEP     = 2'd3
   } csr_idx_type;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

endpackage

// ----- src/bilinear_image_resize.sv -----
// Top level of the bilinear image scaler: source frame memory, read sequencer and blend pipe.
// Depends on bir_pkg and on assert_macros.svh.
//
//   channel   ports                              handshake
//   request   req_start, busy, req_opcode..      accepted when req_start and not busy
//   response  rsp_valid, rsp_out_pixel           one-cycle strobe, cannot be held off
//   csr       csr_valid, csr_ready, csr_index..  written when csr_valid and csr_ready
//
// A write item uses the frame port without raising busy; a compute item reads its four
// neighbors in turn from the single-port frame memory, and busy is held until the last read.
// A result passes the read, blend and output registers after the last neighbor read of its item.
// Reset is synchronous, sets the sizes to 2 and clears steps and pipeline valids; the frame is not cleared.
// The csr port is always ready.
`include "assert_macros.svh"

module bilinear_image_resize (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [bir_pkg::POS_BITS-1:0]          req_pos_x,
   input  logic [bir_pkg::POS_BITS-1:0]          req_pos_y,
   input  logic [bir_pkg::PIXEL_BITS-1:0]        req_src_pixel,
   output logic                                  rsp_valid,
   output logic [bir_pkg::OUT_BITS-1:0]          rsp_out_pixel,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bir_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [bir_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import bir_pkg::*;

   logic [SIZE_BITS-1:0] src_width_ff, src_width_in;
   logic [SIZE_BITS-1:0] src_height_ff, src_height_in;
   logic [STEP_BITS-1:0] x_step_ff, x_step_in;
   logic [STEP_BITS-1:0] y_step_ff, y_step_in;

   logic                 s1_valid_ff, s1_valid_in;
   op_type               s1_op_ff, s1_op_in;
   logic [POS_BITS-1:0]  s1_px_ff, s1_px_in;
   logic [POS_BITS-1:0]  s1_py_ff, s1_py_in;
   pixel_type            s1_pix_ff, s1_pix_in;
   logic [PROD_BITS-1:0] posx_ff, posx_in;
   logic [PROD_BITS-1:0] posy_ff, posy_in;
   logic [1:0]           cnt_ff, cnt_in;

   logic                 rd_valid_ff, rd_valid_in;
   logic [1:0]           rd_sel_ff, rd_sel_in;
   logic [FRAC_BITS-1:0] fx_ff, fx_in;
   logic [FRAC_BITS-1:0] fy_ff, fy_in;
   pixel_type            pa_ff, pa_in;
   pixel_type            pb_ff, pb_in;
   pixel_type            pc_ff, pc_in;

   logic                 b1_valid_ff, b1_valid_in;
   logic [HSUM_BITS-1:0] h0_ff [3];
   logic [HSUM_BITS-1:0] h0_in [3];
   logic [HSUM_BITS-1:0] h1_ff [3];
   logic [HSUM_BITS-1:0] h1_in [3];
   logic [FRAC_BITS-1:0] b1_fy_ff, b1_fy_in;

   logic                 out_valid_ff, out_valid_in;
   logic [OUT_BITS-1:0]  out_pixel_ff, out_pixel_in;

   pixel_type            frame_mem [FRAME_DEPTH];
   pixel_type            mem_q_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_BITS-1:0] mem_addr;

   logic                 accept, s1_done, last_rd, blend_go;
   logic [SIZE_BITS-1:0] w_eff, h_eff, w_lim, h_lim;
   logic [COL_BITS-1:0]  ix, rd_col;
   logic [ROW_BITS-1:0]  iy, rd_row;
   logic [FRAC_BITS:0]   gx, gy;
   logic [VSUM_BITS-1:0] vsum [3];

   assign csr_ready = 1'b1;

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      x_step_in     = x_step_ff;
      y_step_in     = y_step_ff;
      if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_in  = csr_data[SIZE_BITS-1:0];
            CSR_SRC_HEIGHT: src_height_in = csr_data[SIZE_BITS-1:0];
            CSR_X_STEP:     x_step_in     = csr_data;
            CSR_Y_STEP:     y_step_in     = csr_data;
            default:        src_width_in  = src_width_ff;
         endcase
      end
   end

   always_comb begin
      if (src_width_ff < SIZE_BITS'(2)) begin
         w_eff = SIZE_BITS'(2);
      end else if (src_width_ff > SIZE_BITS'(MAX_SRC_WIDTH)) begin
         w_eff = SIZE_BITS'(MAX_SRC_WIDTH);
      end else begin
         w_eff = src_width_ff;
      end
      if (src_height_ff < SIZE_BITS'(2)) begin
         h_eff = SIZE_BITS'(2);
      end else if (src_height_ff > SIZE_BITS'(MAX_SRC_HEIGHT)) begin
         h_eff = SIZE_BITS'(MAX_SRC_HEIGHT);
      end else begin
         h_eff = src_height_ff;
      end
      w_lim = w_eff - SIZE_BITS'(2);
      h_lim = h_eff - SIZE_BITS'(2);
   end

   assign s1_done = s1_valid_ff && ((s1_op_ff == OP_WRITE) || (cnt_ff == 2'd3));
   assign busy    = s1_valid_ff && !s1_done;
   assign accept  = req_start && !busy;
   assign last_rd = s1_valid_ff && (s1_op_ff == OP_COMPUTE) && (cnt_ff == 2'd3);

   always_comb begin
      s1_op_in  = s1_op_ff;
      s1_px_in  = s1_px_ff;
      s1_py_in  = s1_py_ff;
      s1_pix_in = s1_pix_ff;
      posx_in   = posx_ff;
      posy_in   = posy_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_op_in    = op_type'(req_opcode);
         s1_px_in    = req_pos_x;
         s1_py_in    = req_pos_y;
         s1_pix_in   = req_src_pixel;
         posx_in     = PROD_BITS'(x_step_ff) * PROD_BITS'(req_pos_x);
         posy_in     = PROD_BITS'(y_step_ff) * PROD_BITS'(req_pos_y);
         cnt_in      = 2'd0;
      end else begin
         s1_valid_in = s1_valid_ff && !s1_done;
         cnt_in      = (s1_valid_ff && (s1_op_ff == OP_COMPUTE)) ? cnt_ff + 2'd1 : cnt_ff;
      end
   end

   always_comb begin
      if (posx_ff[PROD_BITS-1:FRAC_BITS] > INT_BITS'(w_lim)) begin
         ix = w_lim[COL_BITS-1:0];
      end else begin
         ix = posx_ff[FRAC_BITS +: COL_BITS];
      end
      if (posy_ff[PROD_BITS-1:FRAC_BITS] > INT_BITS'(h_lim)) begin
         iy = h_lim[ROW_BITS-1:0];
      end else begin
         iy = posy_ff[FRAC_BITS +: ROW_BITS];
      end
      rd_col = ix + COL_BITS'(cnt_ff[0]);
      rd_row = iy + ROW_BITS'(cnt_ff[1]);
      mem_we = s1_valid_ff && (s1_op_ff == OP_WRITE)
               && (s1_px_ff < POS_BITS'(w_eff)) && (s1_py_ff < POS_BITS'(h_eff));
      mem_re = s1_valid_ff && (s1_op_ff == OP_COMPUTE);
      if (s1_op_ff == OP_WRITE) begin
         mem_addr = {s1_py_ff[ROW_BITS-1:0], s1_px_ff[COL_BITS-1:0]};
      end else begin
         mem_addr = {rd_row, rd_col};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= s1_pix_ff;
      end else if (mem_re) begin
         mem_q_ff <= frame_mem[mem_addr];
      end
   end

   assign blend_go = rd_valid_ff && (rd_sel_ff == 2'd3);

   always_comb begin
      rd_valid_in = mem_re;
      rd_sel_in   = cnt_ff;
      fx_in       = last_rd ? posx_ff[FRAC_BITS-1:0] : fx_ff;
      fy_in       = last_rd ? posy_ff[FRAC_BITS-1:0] : fy_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      pc_in       = pc_ff;
      if (rd_valid_ff) begin
         case (rd_sel_ff)
            2'd0:    pa_in = mem_q_ff;
            2'd1:    pb_in = mem_q_ff;
            2'd2:    pc_in = mem_q_ff;
            default: pa_in = pa_ff;
         endcase
      end
   end

   always_comb begin
      gx = ONE_FRAC - (FRAC_BITS+1)'(fx_ff);
      b1_valid_in = blend_go;
      b1_fy_in    = fy_ff;
      for (int ch = 0; ch < 3; ch++) begin
         h0_in[ch] = HSUM_BITS'(pa_ff[8*ch +: 8]) * HSUM_BITS'(gx)
                     + HSUM_BITS'(pb_ff[8*ch +: 8]) * HSUM_BITS'(fx_ff);
         h1_in[ch] = HSUM_BITS'(pc_ff[8*ch +: 8]) * HSUM_BITS'(gx)
                     + HSUM_BITS'(mem_q_ff[8*ch +: 8]) * HSUM_BITS'(fx_ff);
      end
   end

   always_comb begin
      gy = ONE_FRAC - (FRAC_BITS+1)'(b1_fy_ff);
      out_valid_in = b1_valid_ff;
      for (int ch = 0; ch < 3; ch++) begin
         vsum[ch] = VSUM_BITS'(h0_ff[ch]) * VSUM_BITS'(gy)
                    + VSUM_BITS'(h1_ff[ch]) * VSUM_BITS'(b1_fy_ff);
      end
      out_pixel_in = {ALPHA, vsum[2][VSUM_BITS-1 -: 8], vsum[1][VSUM_BITS-1 -: 8],
                      vsum[0][VSUM_BITS-1 -: 8]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_BITS'(2);
         src_height_ff <= SIZE_BITS'(2);
         x_step_ff     <= '0;
         y_step_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         cnt_ff        <= 2'd0;
         rd_valid_ff   <= 1'b0;
         b1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         x_step_ff     <= x_step_in;
         y_step_ff     <= y_step_in;
         s1_valid_ff   <= s1_valid_in;
         cnt_ff        <= cnt_in;
         rd_valid_ff   <= rd_valid_in;
         b1_valid_ff   <= b1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_px_ff     <= s1_px_in;
      s1_py_ff     <= s1_py_in;
      s1_pix_ff    <= s1_pix_in;
      posx_ff      <= posx_in;
      posy_ff      <= posy_in;
      rd_sel_ff    <= rd_sel_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      pc_ff        <= pc_in;
      h0_ff        <= h0_in;
      h1_ff        <= h1_in;
      b1_fy_ff     <= b1_fy_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_pixel = out_pixel_ff;

   `ASSERT_SYNC(a_compute_holds_port,
      (accept && req_opcode == OP_COMPUTE) |=> busy ##1 busy ##1 busy ##1 !busy,
      "compute item did not hold the frame port for four cycles")
   `ASSERT_SYNC(a_write_one_cycle, (accept && req_opcode == OP_WRITE) |=> !busy,
      "write item held the frame port for more than one cycle")
   `ASSERT_SYNC(a_rsp_follows_reads, rsp_valid |-> $past(last_rd, 3),
      "result strobe without a finished set of neighbor reads")
   `ASSERT_SYNC(a_new_item_starts_at_a, $past(accept) |-> (cnt_ff == 2'd0),
      "new item did not start with the first neighbor read")
   `ASSERT_ALWAYS(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid,
      "result strobe right after reset")

endmodule
